// ----- design/i2csre_pkg.sv -----
`timescale 1ns / 1ps

package i2csre_pkg;

  // event codes from the bus controller
  typedef enum logic [2:0] {
    ACT_ADDR_WRITE = 3'd0,
    ACT_DATA_WRITE = 3'd1,
    ACT_ADDR_READ  = 3'd2,
    ACT_DATA_READ  = 3'd3,
    ACT_NACK       = 3'd4,
    ACT_ENCODER    = 3'd5,
    ACT_HEARTBEAT  = 3'd6
  } action_t;

  // write transaction pointer phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ARMED  = 2'd1,
    PH_LOADED = 2'd2
  } phase_t;

  // fixed register locations and reset values
  localparam logic [7:0]  IDX_VERSION   = 8'd0;
  localparam logic [7:0]  IDX_HEARTBEAT = 8'd2;
  localparam logic [7:0]  IDX_COUNT_LO  = 8'd4;
  localparam logic [7:0]  IDX_COUNT_HI  = 8'd5;
  localparam logic [7:0]  VERSION_RESET = 8'd15;
  localparam logic [15:0] COUNT_RESET   = 16'd8389;

  // request from the control path to the register file
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic       enc_en;
    logic       enc_up;
    logic       hb_en;
    logic [7:0] idx;
    logic [7:0] wdata;
  } rf_req_t;

endpackage

// ----- design/i2csre_regfile.sv -----
`timescale 1ns / 1ps

module i2csre_regfile import i2csre_pkg::*; #(
  parameter int REGISTER_BYTES = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rf_req_t    req,
  output logic [7:0] rd_data
);

  localparam int AW = $clog2(REGISTER_BYTES);

  logic [7:0]                mem [REGISTER_BYTES];
  logic [REGISTER_BYTES-1:0] vld_r;
  logic [7:0]                ver_r;
  logic [7:0]                hb_r;
  logic [15:0]               cnt_r;
  logic [7:0]                mem_q_r;
  logic [7:0]                fix_q_r;
  logic                      sel_mem_r;
  logic [AW-1:0]             addr;
  logic                      is_fixed;
  logic [7:0]                fix_val;

  assign addr = req.idx[AW-1:0];

  // bytes with their own registers
  always_comb begin
    is_fixed = 1'b1;
    fix_val  = 8'd0;
    case (req.idx)
      IDX_VERSION:   fix_val = ver_r;
      IDX_HEARTBEAT: fix_val = hb_r;
      IDX_COUNT_LO:  fix_val = cnt_r[7:0];
      IDX_COUNT_HI:  fix_val = cnt_r[15:8];
      default:       is_fixed = 1'b0;
    endcase
  end

  // byte storage and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[addr];
      fix_q_r <= is_fixed ? fix_val : 8'd0;
    end
  end

  // valid bits, fixed bytes, encoder count and heartbeat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ver_r     <= VERSION_RESET;
      hb_r      <= 8'd0;
      cnt_r     <= COUNT_RESET;
      sel_mem_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[addr] <= 1'b1;
        case (req.idx)
          IDX_VERSION:   ver_r        <= req.wdata;
          IDX_HEARTBEAT: hb_r         <= req.wdata;
          IDX_COUNT_LO:  cnt_r[7:0]   <= req.wdata;
          IDX_COUNT_HI:  cnt_r[15:8]  <= req.wdata;
          default:       ;
        endcase
      end
      if (req.enc_en) begin
        cnt_r <= req.enc_up ? cnt_r + 16'd1 : cnt_r - 16'd1;
      end
      if (req.hb_en) begin
        hb_r <= hb_r + 8'd1;
      end
      if (req.rd_en) begin
        sel_mem_r <= !is_fixed && vld_r[addr];
      end
    end
  end

  assign rd_data = sel_mem_r ? mem_q_r : fix_q_r;

endmodule

// ----- design/i2c_slave_register_file_encoder.sv -----
`timescale 1ns / 1ps
// channel   ports                                                       direction
// in        in_valid in_stall in_action in_bus_byte in_channel_b_level  master -> block
// out       out_valid out_stall out_read_byte                           block -> master
//
// one request per cycle while the input is not stalled; a read request's byte passes
// through the input register, then the register file read into the result register
// all work happens in a single pass from the input register; stall only when
// a read waits on a full, stalled result register
// rst_n is synchronous; register bytes return to their reset values at once

module i2c_slave_register_file_encoder import i2csre_pkg::*; #(
  parameter int REGISTER_BYTES = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_bus_byte,
  input  logic       in_channel_b_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte
);

  logic       s1_valid_r;
  action_t    s1_act_r;
  logic [7:0] s1_byte_r;
  logic       s1_chb_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] ptr_r;
  logic [7:0] ptr_nxt;
  phase_t     phase_r;
  phase_t     phase_nxt;
  rf_req_t    req;
  logic       is_read;
  logic       s1_go;
  logic       s1_proc;
  logic       in_accept;
  logic       ptr_ok;
  logic [7:0] wptr;
  logic [8:0] wptr_inc;

  // handshake
  assign is_read   = (s1_act_r == ACT_ADDR_READ) || (s1_act_r == ACT_DATA_READ);
  assign s1_go     = !is_read || !out_valid_r || !out_stall;
  assign s1_proc   = s1_valid_r && s1_go;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept || s1_proc) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r  <= action_t'(in_action);
      s1_byte_r <= in_bus_byte;
      s1_chb_r  <= in_channel_b_level;
    end
  end

  // out-of-range pointer wraps to zero before use
  assign ptr_ok   = {1'b0, ptr_r} < 9'(REGISTER_BYTES);
  assign wptr     = ptr_ok ? ptr_r : 8'd0;
  assign wptr_inc = {1'b0, wptr} + 9'd1;

  // pointer phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (s1_proc) begin
      unique case (s1_act_r) inside
        ACT_ADDR_WRITE: phase_nxt = PH_ARMED;
        ACT_DATA_WRITE: begin
          if (phase_r == PH_ARMED) begin
            phase_nxt = PH_LOADED;
          end
        end
        default: ;
      endcase
    end
  end

  // pointer update and register file request
  always_comb begin
    ptr_nxt    = ptr_r;
    req        = '0;
    req.idx    = wptr;
    req.wdata  = s1_byte_r;
    req.enc_up = s1_chb_r;
    if (s1_proc) begin
      unique case (s1_act_r) inside
        ACT_ADDR_WRITE: ptr_nxt = 8'd0;
        ACT_DATA_WRITE: begin
          if (phase_r == PH_ARMED) begin
            ptr_nxt = s1_byte_r;
          end else begin
            req.wr_en = 1'b1;
            ptr_nxt   = (wptr_inc == 9'(REGISTER_BYTES)) ? 8'd0 : wptr_inc[7:0];
          end
        end
        ACT_ADDR_READ, ACT_DATA_READ: begin
          req.rd_en = 1'b1;
          ptr_nxt   = wptr_inc[7:0];
        end
        ACT_ENCODER:   req.enc_en = 1'b1;
        ACT_HEARTBEAT: req.hb_en  = 1'b1;
        default: ;
      endcase
    end
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_proc && is_read) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= 8'd0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  i2csre_regfile #(
    .REGISTER_BYTES(REGISTER_BYTES)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (out_read_byte)
  );

  assign out_valid = out_valid_r;

  // a stored byte always leaves the pointer in range
  a_wr_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |=> ({1'b0, ptr_r} < 9'(REGISTER_BYTES)))
    else $error("pointer out of range after a data write");

  // a new result only follows a processed read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(s1_proc && is_read))
    else $error("result without a read request");

  // the pointer phase arms only on an address-with-write request
  a_arm_src: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ARMED && $past(phase_r) != PH_ARMED)
      |-> $past(s1_proc && s1_act_r == ACT_ADDR_WRITE))
    else $error("phase armed without an address write");

  // only a read blocks the input
  a_stall_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && is_read && out_valid_r))
    else $error("stall without a pending read");

endmodule
